// ===== src/bertlv_pkg.sv =====
// Shared types and constants for the BER TLV header parser.
`default_nettype none

package bertlv_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TRUNC   = 3'd1;
  localparam logic [2:0] ST_TAGLONG = 3'd2;
  localparam logic [2:0] ST_LENLONG = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  localparam logic [4:0]  TAG_ESCAPE       = 5'h1F;
  localparam logic [3:0]  TAG_LONG_COUNT   = 4'd5;
  localparam logic [6:0]  MAX_LEN_BYTES    = 7'd4;
  localparam logic [6:0]  LEN_INDEFINITE   = 7'h00;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_IDENT,
    PH_TAG,
    PH_LEN,
    PH_LENB
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  identifier_octet;
    logic [20:0] tag_number;
    logic [31:0] content_length;
    logic        indefinite;
    logic [3:0]  header_size;
  } out_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [20:0] tag_acc;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [3:0]  byte_count;
    logic [7:0]  first_octet;
  } parse_state_t;

  localparam parse_state_t PARSE_IDLE = '{
    phase:       PH_IDENT,
    tag_acc:     21'd0,
    len_acc:     32'd0,
    len_left:    3'd0,
    byte_count:  4'd0,
    first_octet: 8'd0
  };

endpackage

`default_nettype wire

// ===== src/bertlv_step.sv =====
// Next-state and result logic for one input byte of the header parser.
`default_nettype none

module bertlv_step (
  input  bertlv_pkg::parse_state_t cur,
  input  bertlv_pkg::in_word_t     word,
  input  logic [31:0]              max_length,
  output bertlv_pkg::parse_state_t nxt,
  output logic                     emit,
  output bertlv_pkg::out_word_t    res
);
  import bertlv_pkg::*;

  parse_state_t ph;
  logic [3:0]   cnt;
  logic [2:0]   status;
  logic         indef;
  logic [7:0]   b;
  logic         last;

  assign b    = word.in_byte;
  assign last = word.buffer_end;
  assign cnt  = cur.byte_count + 4'd1;

  always_comb begin
    ph            = cur;
    ph.byte_count = cnt;
    emit          = 1'b0;
    status        = ST_OK;
    indef         = 1'b0;
    unique case (cur.phase)
      PH_IDENT: begin
        ph.first_octet = b;
        if (b[4:0] == TAG_ESCAPE) begin
          ph.tag_acc = 21'd0;
          ph.phase   = PH_TAG;
        end else begin
          ph.tag_acc = {16'd0, b[4:0]};
          ph.phase   = PH_LEN;
        end
        if (last) begin
          emit   = 1'b1;
          status = ST_TRUNC;
        end
      end
      PH_TAG: begin
        // A fourth long-form tag byte is swallowed and fails the header.
        if (cnt >= TAG_LONG_COUNT) begin
          emit   = 1'b1;
          status = ST_TAGLONG;
        end else begin
          ph.tag_acc = {cur.tag_acc[13:0], b[6:0]};
          if (!b[7]) begin
            ph.phase = PH_LEN;
          end
          if (last) begin
            emit   = 1'b1;
            status = ST_TRUNC;
          end
        end
      end
      PH_LEN: begin
        if (!b[7]) begin
          ph.len_acc = {24'd0, b};
          emit       = 1'b1;
          status     = (ph.len_acc > max_length) ? ST_OVER : ST_OK;
        end else if (b[6:0] > MAX_LEN_BYTES) begin
          emit   = 1'b1;
          status = ST_LENLONG;
        end else if (b[6:0] == LEN_INDEFINITE) begin
          emit  = 1'b1;
          indef = 1'b1;
        end else begin
          ph.len_acc  = 32'd0;
          ph.len_left = b[2:0];
          ph.phase    = PH_LENB;
          if (last) begin
            emit   = 1'b1;
            status = ST_TRUNC;
          end
        end
      end
      PH_LENB: begin
        ph.len_acc  = {cur.len_acc[23:0], b};
        ph.len_left = (cur.len_left != 3'd0) ? cur.len_left - 3'd1 : 3'd0;
        if (ph.len_left == 3'd0) begin
          emit   = 1'b1;
          status = (ph.len_acc > max_length) ? ST_OVER : ST_OK;
        end else if (last) begin
          emit   = 1'b1;
          status = ST_TRUNC;
        end
      end
      default: begin
        ph = cur;
      end
    endcase
  end

  always_comb begin
    res.status           = status;
    res.identifier_octet = ph.first_octet;
    res.tag_number       = ph.tag_acc;
    res.content_length   = indef ? 32'd0 : ph.len_acc;
    res.indefinite       = indef;
    res.header_size      = cnt;
    nxt                  = emit ? PARSE_IDLE : ph;
  end

endmodule

`default_nettype wire

// ===== src/ber_tlv_header_parser_unit.sv =====
// Top level of the BER TLV header parser: parse state, result register, config.
//
//   channel   direction  handshake                     word
//   item      in         item_valid / item_ready       in_word_t  (in_byte, buffer_end)
//   result    out        result_valid / result_ready   out_word_t (status .. header_size)
//   cfg       in         cfg_we (no wait)              max_length, 32 bits
//
// One input word is taken per cycle while item_ready is high; its result, if any,
// appears in the result register on the next cycle. The parse state updates in the same
// cycle a word is accepted, so throughput is set by the single result register: a new
// word is taken whenever that register is empty or being emptied. Reset is synchronous
// and returns the parser to waiting for an identifier octet with max_length at all ones.
`default_nettype none

module ber_tlv_header_parser_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  bertlv_pkg::in_word_t  item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output bertlv_pkg::out_word_t result,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata
);
  import bertlv_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  logic         step_emit;
  out_word_t    step_res;
  logic [31:0]  max_length;
  logic         accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  bertlv_step u_step (
    .cur        (st),
    .word       (item),
    .max_length (max_length),
    .nxt        (st_next),
    .emit       (step_emit),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= PARSE_IDLE;
      result_valid <= 1'b0;
      max_length   <= MAX_LENGTH_RESET;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      if (accept && step_emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_emit) begin
      result <= step_res;
    end
  end

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    accept && step_emit |=> st.phase == PH_IDENT && st.byte_count == 4'd0)
    else $error("parser did not return to idle after a result");

  a_header_size_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.header_size != 4'd0 && result.header_size <= 4'd9)
    else $error("header size out of range");

  a_indef_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.indefinite |->
      result.content_length == 32'd0 && result.status == ST_OK)
    else $error("indefinite result carries a length or an error");

  a_lenb_pending: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_LENB |-> st.len_left != 3'd0)
    else $error("length byte phase with nothing left to read");

  a_ident_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDENT |-> st.byte_count == 4'd0 && st.len_acc == 32'd0)
    else $error("idle state not cleared");

endmodule

`default_nettype wire
